[rtl/ets_pkg.sv]
// Shared types, codes and default constants for the extended timer event scheduler.
package ets_pkg;

	localparam int unsigned TICKS_PER_US_DEF = 100;
	localparam int unsigned CYCLE_US_DEF     = 1000000;

	localparam logic [2:0] KIND_READ  = 3'd0;
	localparam logic [2:0] KIND_SET   = 3'd1;
	localparam logic [2:0] KIND_CLEAR = 3'd2;
	localparam logic [2:0] KIND_RAISE = 3'd3;
	localparam logic [2:0] KIND_IRQ   = 3'd4;

	localparam logic [1:0] MATCH_LEAVE   = 2'd0;
	localparam logic [1:0] MATCH_PROGRAM = 2'd1;
	localparam logic [1:0] MATCH_IDLE    = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] count;
		logic        interval_wrapped;
		logic [31:0] delay_us;
	} req_item_t;

	typedef struct packed {
		logic [31:0] time_us;
		logic [1:0]  match_action;
		logic [31:0] match_ticks;
		logic        raise_irq;
		logic        signal_expiry;
	} rsp_item_t;

	// scheduler stage result handed to the compare stage
	typedef struct packed {
		logic [31:0] time_us;
		logic [1:0]  match_action;
		logic [31:0] rel_us;
		logic [31:0] count;
		logic        force_irq;
		logic        signal_expiry;
	} sched_res_t;

endpackage

[rtl/ets_div.sv]
// Tick count to microseconds: reciprocal multiply, then one-step remainder correction.
module ets_div #(
	parameter int unsigned TICKS_PER_US = ets_pkg::TICKS_PER_US_DEF
) (
	input  logic              clk,
	input  logic              ld_s1,
	input  logic              ld_s2,
	input  logic              ld_s3,
	input  ets_pkg::req_item_t req,
	output ets_pkg::req_item_t item_s3,
	output logic [31:0]       quot_s3
);

	localparam int unsigned SH = 32 + $clog2(TICKS_PER_US);
	localparam logic [32:0] RECIP = 33'((65'd1 << SH) / TICKS_PER_US);
	localparam logic [31:0] TICKS = 32'(TICKS_PER_US);

	ets_pkg::req_item_t item_s1;
	ets_pkg::req_item_t item_s2;
	logic [31:0] q0_s2;
	logic [64:0] prod;
	logic [63:0] back;
	logic [31:0] rem;
	logic [31:0] quot;

	// estimate is exact or one short
	assign prod = 65'(item_s1.count) * 65'(RECIP);

	assign back = 64'(q0_s2) * 64'(TICKS);
	assign rem  = item_s2.count - back[31:0];
	assign quot = (rem >= TICKS) ? q0_s2 + 32'd1 : q0_s2;

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			item_s1 <= req;
		end
		if (ld_s2) begin
			item_s2 <= item_s1;
			q0_s2   <= 32'(prod >> SH);
		end
		if (ld_s3) begin
			item_s3 <= item_s2;
			quot_s3 <= quot;
		end
	end

endmodule

[rtl/ets_sched.sv]
// Timebase and event state: extends the counter, handles each kind, decides the match action.
module ets_sched #(
	parameter int unsigned CYCLE_US = ets_pkg::CYCLE_US_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ld_s4,
	input  ets_pkg::req_item_t item_s3,
	input  logic [31:0]        quot_s3,
	output ets_pkg::sched_res_t res_s4
);

	localparam logic [31:0] CYCLE = 32'(CYCLE_US);

	logic [31:0] base_q;
	logic [31:0] event_q;
	logic        armed_q;
	logic [31:0] last_q;

	logic [31:0] base_n;
	logic [31:0] event_n;
	logic        armed_n;
	logic [31:0] last_n;
	logic [31:0] now;
	logic [31:0] rel;
	logic        eval;
	logic [31:0] diff_last;
	logic [31:0] diff_event;
	ets_pkg::sched_res_t res;

	always_comb begin
		base_n     = item_s3.interval_wrapped ? base_q + CYCLE : base_q;
		now        = base_n + quot_s3;
		diff_last  = now - last_q;
		diff_event = now - event_q;
		event_n    = event_q;
		armed_n    = armed_q;
		last_n     = last_q;
		rel        = '0;
		eval       = 1'b0;

		res               = '0;
		res.time_us       = now;
		res.count         = item_s3.count;
		res.match_action  = ets_pkg::MATCH_LEAVE;

		case (item_s3.kind)
			ets_pkg::KIND_READ: begin
				if (diff_last[31]) begin
					res.time_us = last_q;
				end else begin
					last_n = now;
				end
			end
			ets_pkg::KIND_SET: begin
				event_n = now + item_s3.delay_us;
				armed_n = 1'b1;
				rel     = quot_s3 + item_s3.delay_us;
				eval    = 1'b1;
			end
			ets_pkg::KIND_CLEAR: begin
				armed_n          = 1'b0;
				res.match_action = ets_pkg::MATCH_IDLE;
			end
			ets_pkg::KIND_RAISE: begin
				event_n       = now;
				armed_n       = 1'b1;
				res.force_irq = 1'b1;
			end
			ets_pkg::KIND_IRQ: begin
				if (armed_q) begin
					if (!diff_event[31]) begin
						armed_n           = 1'b0;
						res.match_action  = ets_pkg::MATCH_IDLE;
						res.signal_expiry = 1'b1;
					end else begin
						rel  = event_q - base_n;
						eval = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		if (eval) begin
			res.match_action = (rel < CYCLE) ? ets_pkg::MATCH_PROGRAM : ets_pkg::MATCH_IDLE;
		end
		res.rel_us = rel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			event_q <= '0;
			armed_q <= 1'b0;
			last_q  <= '0;
		end else if (ld_s4) begin
			base_q  <= base_n;
			event_q <= event_n;
			armed_q <= armed_n;
			last_q  <= last_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			res_s4 <= res;
		end
	end

endmodule

[rtl/ets_match.sv]
// Compare value in ticks and the already-passed check, into the result register.
module ets_match #(
	parameter int unsigned TICKS_PER_US = ets_pkg::TICKS_PER_US_DEF
) (
	input  logic                clk,
	input  logic                ld_s5,
	input  ets_pkg::sched_res_t res_s4,
	output ets_pkg::rsp_item_t  rsp_s5
);

	localparam logic [31:0] TICKS = 32'(TICKS_PER_US);

	logic [63:0] prod;
	logic        prog;
	ets_pkg::rsp_item_t rsp;

	assign prod = 64'(res_s4.rel_us) * 64'(TICKS);
	assign prog = (res_s4.match_action == ets_pkg::MATCH_PROGRAM);

	always_comb begin
		rsp               = '0;
		rsp.time_us       = res_s4.time_us;
		rsp.match_action  = res_s4.match_action;
		rsp.signal_expiry = res_s4.signal_expiry;
		if (prog) begin
			rsp.match_ticks = prod[31:0];
		end
		rsp.raise_irq = res_s4.force_irq || (prog && (res_s4.count >= prod[31:0]));
	end

	always_ff @(posedge clk) begin
		if (ld_s5) begin
			rsp_s5 <= rsp;
		end
	end

endmodule

[rtl/extended_timer_event_scheduler_core.sv]
// Top level of the extended timer event scheduler: stage handshake and unit hookup.
// One beat in gives one beat out once the output side is ready. Unless stalled,
// a new beat is taken every cycle: the pipeline has five registered stages (input,
// reciprocal multiply, remainder correction, timebase/event state, compare multiply),
// each with its own valid bit, so a stalled result only holds back the stages behind
// it that are full. All timebase and event state lives in the fourth stage and is
// updated as a beat passes through it, so beats see each other's effects in order.
// TICKS_PER_US (1 to 1000) sets the tick divider and CYCLE_US the counter cycle length.
module extended_timer_event_scheduler_core #(
	parameter int unsigned TICKS_PER_US = ets_pkg::TICKS_PER_US_DEF,
	parameter int unsigned CYCLE_US     = ets_pkg::CYCLE_US_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  ets_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output ets_pkg::rsp_item_t rsp
);

	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic r1, r2, r3, r4, r5;
	logic ld1, ld2, ld3, ld4, ld5;

	ets_pkg::req_item_t  item_s3;
	logic [31:0]         quot_s3;
	ets_pkg::sched_res_t res_s4;

	assign r5 = !v5_q || rsp_ready;
	assign r4 = !v4_q || r5;
	assign r3 = !v3_q || r4;
	assign r2 = !v2_q || r3;
	assign r1 = !v1_q || r2;

	assign ld1 = req_valid && r1;
	assign ld2 = v1_q && r2;
	assign ld3 = v2_q && r3;
	assign ld4 = v3_q && r4;
	assign ld5 = v4_q && r5;

	assign req_ready = r1;
	assign rsp_valid = v5_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (r1) v1_q <= req_valid;
			if (r2) v2_q <= v1_q;
			if (r3) v3_q <= v2_q;
			if (r4) v4_q <= v3_q;
			if (r5) v5_q <= v4_q;
		end
	end

	ets_div #(
		.TICKS_PER_US(TICKS_PER_US)
	) u_div (
		.clk     (clk),
		.ld_s1   (ld1),
		.ld_s2   (ld2),
		.ld_s3   (ld3),
		.req     (req),
		.item_s3 (item_s3),
		.quot_s3 (quot_s3)
	);

	ets_sched #(
		.CYCLE_US(CYCLE_US)
	) u_sched (
		.clk     (clk),
		.arst_n  (arst_n),
		.ld_s4   (ld4),
		.item_s3 (item_s3),
		.quot_s3 (quot_s3),
		.res_s4  (res_s4)
	);

	ets_match #(
		.TICKS_PER_US(TICKS_PER_US)
	) u_match (
		.clk    (clk),
		.ld_s5  (ld5),
		.res_s4 (res_s4),
		.rsp_s5 (rsp)
	);

endmodule

[dv/tb_extended_timer_event_scheduler_core.sv]
// Testbench for the extended timer event scheduler core: directed and random beats checked in order.
module tb_extended_timer_event_scheduler_core;

	localparam int unsigned TICKS       = ets_pkg::TICKS_PER_US_DEF;
	localparam int unsigned CYCLE       = ets_pkg::CYCLE_US_DEF;
	localparam int unsigned CYCLE_TICKS = TICKS * CYCLE;
	localparam int          STALL_LIMIT = 1000;
	localparam int          HOLD_CYCLES = 64;
	localparam int          BURST_BEATS = 40;
	localparam int          CHUNK_BEATS = 50;
	localparam int          CHUNKS      = 19;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	ets_pkg::req_item_t req;
	logic               rsp_valid;
	logic               rsp_ready;
	ets_pkg::rsp_item_t rsp;

	// predicted timebase and event state
	logic [31:0] epoch_us;
	logic [31:0] alarm_us;
	logic        alarm_on;
	logic [31:0] last_read_us;

	ets_pkg::rsp_item_t pending_rsp[$];
	int          errors       = 0;
	int          stuck_cycles = 0;
	int          rsp_hold     = 0;
	bit          send_gaps    = 1'b0;
	bit          recv_gaps    = 1'b0;
	int unsigned hw_ticks     = 0;

	always #1 clk = ~clk;

	extended_timer_event_scheduler_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	function automatic ets_pkg::rsp_item_t compare_eval(ets_pkg::rsp_item_t o,
			logic [31:0] count);
		logic [31:0] rel_us;
		logic [31:0] ticks;
		rel_us = alarm_us - epoch_us;
		if (rel_us < CYCLE) begin
			ticks = rel_us * TICKS;
			o.match_action = ets_pkg::MATCH_PROGRAM;
			o.match_ticks  = ticks;
			o.raise_irq    = (count >= ticks);
		end else begin
			o.match_action = ets_pkg::MATCH_IDLE;
		end
		return o;
	endfunction

	function automatic ets_pkg::rsp_item_t timebase_step(ets_pkg::req_item_t r);
		ets_pkg::rsp_item_t o;
		logic [31:0] now_us;
		logic [31:0] diff;
		o = '0;
		if (r.interval_wrapped)
			epoch_us = epoch_us + CYCLE;
		now_us = epoch_us + r.count / TICKS;
		o.time_us = now_us;
		case (r.kind)
			ets_pkg::KIND_READ: begin
				diff = now_us - last_read_us;
				if (diff[31])
					o.time_us = last_read_us;
				else
					last_read_us = now_us;
			end
			ets_pkg::KIND_SET: begin
				alarm_us = now_us + r.delay_us;
				alarm_on = 1'b1;
				o = compare_eval(o, r.count);
			end
			ets_pkg::KIND_CLEAR: begin
				alarm_on = 1'b0;
				o.match_action = ets_pkg::MATCH_IDLE;
			end
			ets_pkg::KIND_RAISE: begin
				alarm_us = now_us;
				alarm_on = 1'b1;
				o.raise_irq = 1'b1;
			end
			ets_pkg::KIND_IRQ: begin
				if (alarm_on) begin
					diff = now_us - alarm_us;
					if (!diff[31]) begin
						alarm_on = 1'b0;
						o.match_action  = ets_pkg::MATCH_IDLE;
						o.signal_expiry = 1'b1;
					end else begin
						o = compare_eval(o, r.count);
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic ets_pkg::req_item_t make_beat(logic [2:0] k, logic [31:0] cnt, logic w,
			logic [31:0] d);
		ets_pkg::req_item_t r;
		r.kind             = k;
		r.count            = cnt;
		r.interval_wrapped = w;
		r.delay_us         = d;
		return r;
	endfunction

	// free-running tick counter model with wrap detection
	function automatic ets_pkg::req_item_t counter_beat(logic [2:0] k, logic [31:0] d);
		int unsigned step;
		logic        w;
		step = ($urandom_range(0, 15) == 0) ? $urandom_range(0, CYCLE_TICKS) :
			$urandom_range(0, 40000);
		hw_ticks = hw_ticks + step;
		w = 1'b0;
		if (hw_ticks >= CYCLE_TICKS) begin
			hw_ticks = hw_ticks - CYCLE_TICKS;
			w = 1'b1;
		end
		return make_beat(k, hw_ticks, w, d);
	endfunction

	function automatic ets_pkg::req_item_t traffic_beat();
		int unsigned pick;
		logic [2:0]  k;
		logic [31:0] d;
		if ($urandom_range(0, 99) < 15)
			return make_beat(3'($urandom_range(0, 7)), $urandom,
				1'($urandom_range(0, 1)), $urandom);
		pick = $urandom_range(0, 99);
		if (pick < 25)
			k = ets_pkg::KIND_READ;
		else if (pick < 45)
			k = ets_pkg::KIND_SET;
		else if (pick < 55)
			k = ets_pkg::KIND_CLEAR;
		else if (pick < 62)
			k = ets_pkg::KIND_RAISE;
		else if (pick < 97)
			k = ets_pkg::KIND_IRQ;
		else
			k = 3'(ets_pkg::KIND_IRQ + $urandom_range(1, 3));
		pick = $urandom_range(0, 99);
		if (pick < 60)
			d = $urandom_range(0, 3000);
		else if (pick < 85)
			d = $urandom_range(0, 2 * CYCLE);
		else
			d = $urandom;
		return counter_beat(k, d);
	endfunction

	task automatic send_beat(input ets_pkg::req_item_t item);
		int unsigned gap;
		gap = send_gaps ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pending_rsp.push_back(timebase_step(item));
		@(negedge clk);
	endtask

	task automatic wait_all_done();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_kind_corners();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		send_beat(make_beat(ets_pkg::KIND_READ, 32'd0, 1'b0, 32'd0));
		send_beat(make_beat(ets_pkg::KIND_READ, '1, 1'b0, '1));
		// time going backwards is clamped
		send_beat(make_beat(ets_pkg::KIND_READ, 32'd0, 1'b0, 32'd0));
		send_beat(make_beat(ets_pkg::KIND_READ, 32'd0, 1'b1, 32'd0));
		send_beat(make_beat(ets_pkg::KIND_READ, 32'h8000_0000, 1'b0, 32'd0));
		send_beat(make_beat(ets_pkg::KIND_IRQ, 32'd0, 1'b0, 32'd0));
		send_beat(make_beat(ets_pkg::KIND_SET, 32'd500, 1'b0, 32'd0));
		send_beat(make_beat(ets_pkg::KIND_IRQ, 32'd500, 1'b0, 32'd0));
		send_beat(make_beat(ets_pkg::KIND_SET, 32'd0, 1'b0, '1));
		send_beat(make_beat(ets_pkg::KIND_IRQ, 32'd0, 1'b0, 32'd0));
		send_beat(make_beat(ets_pkg::KIND_SET, 32'd100, 1'b0, CYCLE - 2));
		send_beat(make_beat(ets_pkg::KIND_IRQ, 32'd200, 1'b0, 32'd0));
		send_beat(make_beat(ets_pkg::KIND_SET, 32'd0, 1'b0, CYCLE));
		send_beat(make_beat(ets_pkg::KIND_IRQ, 32'd300, 1'b0, 32'd0));
		send_beat(make_beat(ets_pkg::KIND_CLEAR, 32'd0, 1'b0, 32'd0));
		send_beat(make_beat(ets_pkg::KIND_IRQ, 32'd0, 1'b0, 32'd0));
		send_beat(make_beat(ets_pkg::KIND_RAISE, 32'd12345, 1'b0, '1));
		send_beat(make_beat(ets_pkg::KIND_IRQ, 32'd12345, 1'b0, 32'd0));
		send_beat(make_beat(ets_pkg::KIND_IRQ + 3'd1, '1, 1'b1, '1));
		send_beat(make_beat(ets_pkg::KIND_IRQ + 3'd2, 32'd0, 1'b1, 32'd0));
		send_beat(make_beat(ets_pkg::KIND_IRQ + 3'd3, '1, 1'b0, '1));
		send_beat(make_beat(ets_pkg::KIND_SET, CYCLE_TICKS - 1, 1'b1, 32'd1));
		send_beat(make_beat(ets_pkg::KIND_IRQ, CYCLE_TICKS - 1, 1'b0, 32'd0));
		send_beat(make_beat(ets_pkg::KIND_READ, 32'd0, 1'b1, 32'd0));
		wait_all_done();
	endtask

	task automatic test_output_backpressure();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		rsp_hold  = HOLD_CYCLES;
		repeat (BURST_BEATS) send_beat(traffic_beat());
		wait_all_done();
	endtask

	task automatic test_drain_pause();
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		repeat (20) send_beat(traffic_beat());
		wait_all_done();
		repeat (20) send_beat(traffic_beat());
		wait_all_done();
	endtask

	task automatic test_random_traffic();
		for (int c = 0; c < CHUNKS; c++) begin
			send_gaps = ($urandom_range(0, 3) != 0);
			recv_gaps = ($urandom_range(0, 3) != 0);
			repeat (CHUNK_BEATS) send_beat(traffic_beat());
			if ($urandom_range(0, 3) == 0)
				wait_all_done();
		end
		wait_all_done();
	endtask

	initial begin : rsp_side
		int unsigned hold;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (rsp_hold != 0) begin
				hold     = rsp_hold;
				rsp_hold = 0;
			end else begin
				hold = recv_gaps ? $urandom_range(0, 6) : 0;
			end
			if (hold != 0) begin
				rsp_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin : rsp_check
		ets_pkg::rsp_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected result beat: time_us %0d", rsp.time_us);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.time_us !== want.time_us) begin
					$error("time_us: expected %0d, got %0d", want.time_us, rsp.time_us);
					errors++;
				end
				if (rsp.match_action !== want.match_action) begin
					$error("match_action: expected %0d, got %0d", want.match_action,
						rsp.match_action);
					errors++;
				end
				if (rsp.match_ticks !== want.match_ticks) begin
					$error("match_ticks: expected %0d, got %0d", want.match_ticks,
						rsp.match_ticks);
					errors++;
				end
				if (rsp.raise_irq !== want.raise_irq) begin
					$error("raise_irq: expected %0d, got %0d", want.raise_irq, rsp.raise_irq);
					errors++;
				end
				if (rsp.signal_expiry !== want.signal_expiry) begin
					$error("signal_expiry: expected %0d, got %0d", want.signal_expiry,
						rsp.signal_expiry);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		epoch_us     = '0;
		alarm_us     = '0;
		alarm_on     = 1'b0;
		last_read_us = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_kind_corners();
		test_output_backpressure();
		test_drain_pause();
		test_random_traffic();
		wait_all_done();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
